// ===== sv/rxrl_pkg.sv =====
// ----------------------------------------------------------------------------
// rxrl_pkg
// Shared types and constants of the receive ring line reader.
// ----------------------------------------------------------------------------
`default_nettype none

package rxrl_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_FLUSH = 2'd3
  } op_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FINAL = 5'b10000
  } state_e;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [6:0] MAX_LEN_RESET = 7'd64;
  localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== sv/rxrl_ram.sv =====
// ----------------------------------------------------------------------------
// rxrl_ram
// Simple dual-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rxrl_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read of the entry being written returns old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rx_ring_line_reader.sv =====
// Per item: apply the op in idle; for an open read, check the timeout, drain the ring
// and emit any completed line, one character per result; then give the final result.
// The single ring read port drains one byte a cycle; the line RAM emits one a cycle
// while the output is not stalled. A new item is taken only in idle.
// Reset (rst_ni low, asynchronous) empties the ring, closes any read, sets max_len to 64.
// ----------------------------------------------------------------------------
// rx_ring_line_reader
// Receive ring buffer that feeds a line assembler with a tick timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module rx_ring_line_reader #(
  parameter int unsigned RING_DEPTH    = 256,
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_data_i,
  // Input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [31:0] timeout_i,
  // Results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       char_out_o,
  output logic [5:0]       length_o,
  output logic [7:0]       pending_o,
  output logic             dropped_o,
  output logic             last_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned LW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int unsigned CW = (AW + 1 > 8) ? AW + 1 : 8;

  // Control registers.
  rxrl_pkg::state_e state_q, state_d;
  logic [AW-1:0]    wr_q, wr_d;
  logic [AW-1:0]    rd_q, rd_d;
  logic [5:0]       line_len_q, line_len_d;
  logic             reading_q, reading_d;
  logic [31:0]      elapsed_q, elapsed_d;
  logic [31:0]      limit_q, limit_d;
  logic [6:0]       max_len_q;
  logic [LW-1:0]    emit_q, emit_d;
  rxrl_pkg::kind_e  final_kind_q, final_kind_d;
  logic             drop_q, drop_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  rxrl_pkg::kind_e  kind_q, kind_d;
  logic [7:0]       char_q, char_d;
  logic [5:0]       length_q, length_d;
  logic [7:0]       pending_q, pending_d;
  logic             dropped_q, dropped_d;
  logic             last_q, last_d;

  // Memory ports.
  logic          ring_we, ring_re;
  logic [7:0]    ring_rdata;
  logic          line_we, line_re;
  logic [7:0]    line_rdata;

  logic          in_beat, out_free, push;
  logic [AW-1:0] wr_next, rd_next;
  logic [CW-1:0] count;
  logic [6:0]    cap_len, keep_lim;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Ring index arithmetic, modulo the ring depth.
  assign wr_next = (wr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_q + AW'(1);
  assign rd_next = (rd_q == AW'(RING_DEPTH - 1)) ? '0 : rd_q + AW'(1);
  assign count   = CW'(wr_q) - CW'(rd_q) + ((wr_q < rd_q) ? CW'(RING_DEPTH) : CW'(0));

  // Number of characters the line may keep.
  assign cap_len  = (max_len_q > 7'(LINE_CAPACITY)) ? 7'(LINE_CAPACITY) : max_len_q;
  assign keep_lim = (cap_len == 7'd0) ? 7'd0 : cap_len - 7'd1;

  // Sequencer: apply the op, check the timeout, drain the ring, emit the line, give the final result.
  always_comb begin
    state_d      = state_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    line_len_d   = line_len_q;
    reading_d    = reading_q;
    elapsed_d    = elapsed_q;
    limit_d      = limit_q;
    emit_d       = emit_q;
    final_kind_d = final_kind_q;
    drop_d       = drop_q;
    ring_we      = 1'b0;
    line_we      = 1'b0;
    push         = 1'b0;
    kind_d       = kind_q;
    char_d       = char_q;
    length_d     = length_q;
    last_d       = last_q;

    unique case (state_q)
      rxrl_pkg::ST_IDLE: begin
        if (in_beat) begin
          drop_d       = 1'b0;
          final_kind_d = rxrl_pkg::KIND_STATUS;
          state_d      = rxrl_pkg::ST_CHECK;
          unique case (rxrl_pkg::op_e'(op_i))
            rxrl_pkg::OP_BYTE: begin
              if (wr_next != rd_q) begin
                ring_we = 1'b1;
                wr_d    = wr_next;
              end else begin
                drop_d = 1'b1;
              end
            end
            rxrl_pkg::OP_TICK: begin
              if (elapsed_q != rxrl_pkg::TICKS_MAX) begin
                elapsed_d = elapsed_q + 32'd1;
              end
            end
            rxrl_pkg::OP_START: begin
              reading_d  = 1'b1;
              elapsed_d  = '0;
              limit_d    = timeout_i;
              line_len_d = '0;
            end
            rxrl_pkg::OP_FLUSH: begin
              rd_d = wr_q;
            end
            default: ;
          endcase
        end
      end

      rxrl_pkg::ST_CHECK: begin
        if (!reading_q) begin
          state_d = rxrl_pkg::ST_FINAL;
        end else if (elapsed_q >= limit_q) begin
          reading_d    = 1'b0;
          final_kind_d = rxrl_pkg::KIND_TIMEOUT;
          state_d      = rxrl_pkg::ST_FINAL;
        end else begin
          state_d = rxrl_pkg::ST_DRAIN;
        end
      end

      // The read register holds the ring entry at rd_q throughout this state.
      rxrl_pkg::ST_DRAIN: begin
        if (rd_q == wr_q) begin
          state_d = rxrl_pkg::ST_FINAL;
        end else begin
          rd_d = rd_next;
          if (ring_rdata == rxrl_pkg::CHAR_NL) begin
            reading_d    = 1'b0;
            final_kind_d = rxrl_pkg::KIND_DONE;
            emit_d       = '0;
            state_d      = (line_len_q != 6'd0) ? rxrl_pkg::ST_EMIT : rxrl_pkg::ST_FINAL;
          end else if (ring_rdata != rxrl_pkg::CHAR_CR) begin
            if ({1'b0, line_len_q} < keep_lim) begin
              line_we    = 1'b1;
              line_len_d = line_len_q + 6'd1;
            end
          end
        end
      end

      // One stored character a beat; the line RAM prefetches the next one.
      rxrl_pkg::ST_EMIT: begin
        if (out_free) begin
          push     = 1'b1;
          kind_d   = rxrl_pkg::KIND_CHAR;
          char_d   = line_rdata;
          length_d = 6'(emit_q) + 6'd1;
          last_d   = 1'b0;
          if (6'(emit_q) + 6'd1 == line_len_q) begin
            state_d = rxrl_pkg::ST_FINAL;
          end else begin
            emit_d = emit_q + LW'(1);
          end
        end
      end

      rxrl_pkg::ST_FINAL: begin
        if (out_free) begin
          push     = 1'b1;
          kind_d   = final_kind_q;
          char_d   = '0;
          length_d = line_len_q;
          last_d   = 1'b1;
          state_d  = rxrl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rxrl_pkg::ST_IDLE;
      end
    endcase
  end

  // Reads follow the next index so that the data is ready in the next cycle.
  assign ring_re = (state_d == rxrl_pkg::ST_DRAIN);
  assign line_re = (state_d == rxrl_pkg::ST_EMIT);

  // Every result of an item carries the ring fill level after the item.
  assign pending_d   = push ? count[7:0] : pending_q;
  assign dropped_d   = push ? drop_q : dropped_q;
  assign out_valid_d = push ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rxrl_pkg::ST_IDLE;
      wr_q         <= '0;
      rd_q         <= '0;
      line_len_q   <= '0;
      reading_q    <= 1'b0;
      elapsed_q    <= '0;
      limit_q      <= '0;
      max_len_q    <= rxrl_pkg::MAX_LEN_RESET;
      out_valid_q  <= 1'b0;
      final_kind_q <= rxrl_pkg::KIND_STATUS;
    end else begin
      state_q      <= state_d;
      wr_q         <= wr_d;
      rd_q         <= rd_d;
      line_len_q   <= line_len_d;
      reading_q    <= reading_d;
      elapsed_q    <= elapsed_d;
      limit_q      <= limit_d;
      out_valid_q  <= out_valid_d;
      final_kind_q <= final_kind_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    emit_q    <= emit_d;
    drop_q    <= drop_d;
    kind_q    <= kind_d;
    char_q    <= char_d;
    length_q  <= length_d;
    pending_q <= pending_d;
    dropped_q <= dropped_d;
    last_q    <= last_d;
  end

  // Ring store and line store.
  rxrl_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (8),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wr_q),
    .wdata_i (data_i),
    .re_i    (ring_re),
    .raddr_i (rd_d),
    .rdata_o (ring_rdata)
  );

  rxrl_ram #(
    .DEPTH (LINE_CAPACITY),
    .WIDTH (8),
    .AW    (LW)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_len_q[LW-1:0]),
    .wdata_i (ring_rdata),
    .re_i    (line_re),
    .raddr_i (emit_d),
    .rdata_o (line_rdata)
  );

  assign in_stall_o  = (state_q != rxrl_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_out_o  = char_q;
  assign length_o    = length_q;
  assign pending_o   = pending_q;
  assign dropped_o   = dropped_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  // The line never holds more than its capacity minus one.
  a_line_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, line_len_q} < 7'(LINE_CAPACITY))
    else $error("line length beyond capacity");

  // Emission stays inside the stored line.
  a_emit_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rxrl_pkg::ST_EMIT) |-> (6'(emit_q) < line_len_q))
    else $error("emit index past line length");

  // The ring is written only by an accepted byte beat.
  a_ring_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (in_beat && (state_q == rxrl_pkg::ST_IDLE)))
    else $error("ring written outside an accepted beat");

  // The final result of an item returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && last_d) |=> (state_q == rxrl_pkg::ST_IDLE))
    else $error("final result did not end the item");
`endif

endmodule

`default_nettype wire

// ===== bench/rx_ring_line_reader_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_ring_line_reader_test
// Self-checking bench for the receive ring line reader. Items are driven
// through the valid/stall input channel while a behavioral copy of the ring,
// the line buffer and the tick timer predicts every result beat. A monitor
// compares each accepted result beat, field by field, with the oldest
// prediction. The sender idles in random gaps and the receiver stalls at random.
// ----------------------------------------------------------------------------

module rx_ring_line_reader_test;

  // One predicted result beat.
  typedef struct packed {
    rxrl_pkg::kind_e kind;
    logic [7:0]      ch;
    logic [5:0]      len;
    logic [7:0]      pend;
    logic            drop;
    logic            last;
  } reader_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [6:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i        = '0;
  logic [7:0]  data_i      = '0;
  logic [31:0] timeout_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  char_out_o;
  logic [5:0]  length_o;
  logic [7:0]  pending_o;
  logic        dropped_o;
  logic        last_o;

  // Shadow state of the block.
  logic [7:0]   ring_mem [256];
  logic [7:0]   ring_wr = '0;
  logic [7:0]   ring_rd = '0;
  logic [7:0]   line_mem [64];
  int unsigned  line_len = 0;
  bit           reading = 1'b0;
  logic [31:0]  ticks = '0;
  logic [31:0]  tick_budget = '0;
  logic [6:0]   cfg_max_len = rxrl_pkg::MAX_LEN_RESET;

  reader_beat_t awaited_beats [$];
  int unsigned  fails = 0;
  bit           gaps_on = 1'b0;
  int unsigned  burst_left = 0;
  bit           valid_held = 1'b0;
  int unsigned  stall_run = 0;
  int unsigned  stall_mode = 0;

  rx_ring_line_reader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_i      (data_i),
    .timeout_i   (timeout_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .char_out_o  (char_out_o),
    .length_o    (length_o),
    .pending_o   (pending_o),
    .dropped_o   (dropped_o),
    .last_o      (last_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake or missing results.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic reader_beat_t make_beat(rxrl_pkg::kind_e kind, logic [7:0] ch,
                                             int unsigned len, logic drop, logic last);
    reader_beat_t b;
    b.kind = kind;
    b.ch   = ch;
    b.len  = len[5:0];
    b.pend = '0;
    b.drop = drop;
    b.last = last;
    return b;
  endfunction

  // Apply one accepted item to the shadow state and queue its result beats.
  task automatic model_line_reader(input rxrl_pkg::op_e op, input logic [7:0] data,
                                   input logic [31:0] tmo);
    reader_beat_t    beats [$];
    logic [7:0]      nxt;
    logic [7:0]      c;
    logic            lost;
    rxrl_pkg::kind_e fin;
    int unsigned     keep;
    lost = 1'b0;
    fin  = rxrl_pkg::KIND_STATUS;
    // Characters kept per line: one less than the size, capped by capacity.
    if (cfg_max_len == 0) keep = 0;
    else if (cfg_max_len > 64) keep = 63;
    else keep = 32'(cfg_max_len) - 1;
    case (op)
      rxrl_pkg::OP_BYTE: begin
        nxt = ring_wr + 8'd1;
        if (nxt != ring_rd) begin
          ring_mem[ring_wr] = data;
          ring_wr = nxt;
        end else begin
          lost = 1'b1;
        end
      end
      rxrl_pkg::OP_TICK: begin
        if (ticks != rxrl_pkg::TICKS_MAX) ticks = ticks + 32'd1;
      end
      rxrl_pkg::OP_START: begin
        reading     = 1'b1;
        ticks       = '0;
        tick_budget = tmo;
        line_len    = 0;
      end
      default: begin
        ring_rd = ring_wr;
      end
    endcase
    // An open read checks its budget first, then drains the ring.
    if (reading) begin
      if (ticks >= tick_budget) begin
        reading = 1'b0;
        fin     = rxrl_pkg::KIND_TIMEOUT;
      end else begin
        while (reading && ring_rd != ring_wr) begin
          c = ring_mem[ring_rd];
          ring_rd = ring_rd + 8'd1;
          if (c == rxrl_pkg::CHAR_NL) begin
            for (int unsigned j = 0; j < line_len; j++)
              beats.push_back(make_beat(rxrl_pkg::KIND_CHAR, line_mem[j[5:0]], j + 1,
                                        lost, 1'b0));
            reading = 1'b0;
            fin     = rxrl_pkg::KIND_DONE;
          end else if (c != rxrl_pkg::CHAR_CR && line_len < keep) begin
            line_mem[line_len[5:0]] = c;
            line_len++;
          end
        end
      end
    end
    beats.push_back(make_beat(fin, 8'd0, line_len, lost, 1'b1));
    foreach (beats[i]) begin
      beats[i].pend = ring_wr - ring_rd;
      awaited_beats.push_back(beats[i]);
    end
  endtask

  // Send one item beat; the sender works in bursts with random gaps while gaps_on is set.
  task automatic send_item(input rxrl_pkg::op_e op, input logic [7:0] data,
                           input logic [31:0] tmo);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (valid_held && gap > 0) begin
        in_valid_i <= 1'b0;
        valid_held = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    valid_held = 1'b1;
    op_i       <= op;
    data_i     <= data;
    timeout_i  <= tmo;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    model_line_reader(op, data, tmo);
  endtask

  // Drop valid and wait until every predicted beat has been seen.
  task automatic wait_idle();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    burst_left = 0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the line size register; only called while the block is idle.
  task automatic write_max_len(input logic [6:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_max_len = value;
  endtask

  // Carriage return skipping, bytes behind a newline, timeouts, flushes.
  task automatic test_directed();
    gaps_on = 1'b0;
    send_item(rxrl_pkg::OP_BYTE, "h", '0);
    send_item(rxrl_pkg::OP_BYTE, "i", '1);
    send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_CR, '0);
    send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_NL, '0);
    send_item(rxrl_pkg::OP_BYTE, "z", '0);
    send_item(rxrl_pkg::OP_START, 8'hFF, rxrl_pkg::TICKS_MAX);
    send_item(rxrl_pkg::OP_FLUSH, 8'h00, '0);
    send_item(rxrl_pkg::OP_START, 8'h00, 32'd2);
    send_item(rxrl_pkg::OP_BYTE, 8'h00, '0);
    send_item(rxrl_pkg::OP_BYTE, 8'hFF, '0);
    send_item(rxrl_pkg::OP_TICK, 8'h00, '0);
    send_item(rxrl_pkg::OP_TICK, 8'h00, '0);
    // A zero budget times out on the start item itself.
    send_item(rxrl_pkg::OP_START, 8'h00, 32'd0);
    send_item(rxrl_pkg::OP_BYTE, "a", '0);
    send_item(rxrl_pkg::OP_TICK, 8'h00, '0);
    send_item(rxrl_pkg::OP_START, 8'h00, 32'd10);
    // Flushing during a read keeps the read open.
    send_item(rxrl_pkg::OP_FLUSH, 8'h00, '0);
    send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_NL, '0);
    wait_idle();
  endtask

  // Line size extremes, including zero and sizes above the line capacity.
  task automatic test_line_limits();
    logic [6:0] sizes [5];
    sizes = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd6};
    gaps_on = 1'b1;
    foreach (sizes[k]) begin
      write_max_len(sizes[k]);
      send_item(rxrl_pkg::OP_START, 8'h00, 32'hFFFF_0000);
      for (int i = 0; i < 5; i++) send_item(rxrl_pkg::OP_BYTE, 8'h41 + i[7:0], $urandom);
      send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_CR, $urandom);
      send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_NL, $urandom);
      wait_idle();
    end
  endtask

  // Build a backlog in the ring while no read is open, then open one read that drains it up to its first newline.
  task automatic test_ring_backlog();
    write_max_len(rxrl_pkg::MAX_LEN_RESET);
    gaps_on = 1'b1;
    send_item(rxrl_pkg::OP_START, 8'h00, 32'd0);
    send_item(rxrl_pkg::OP_FLUSH, 8'h00, $urandom);
    for (int i = 0; i < 40; i++)
      send_item(rxrl_pkg::OP_BYTE, 8'($urandom_range(0, 255)), $urandom);
    send_item(rxrl_pkg::OP_TICK, 8'h00, $urandom);
    send_item(rxrl_pkg::OP_START, 8'h00, rxrl_pkg::TICKS_MAX);
    send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_NL, $urandom);
    send_item(rxrl_pkg::OP_FLUSH, 8'h00, $urandom);
    wait_idle();
  endtask

  // Mostly well-formed line reads with random content, the rest random noise.
  task automatic test_random();
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    for (int phase = 0; phase < 3; phase++) begin
      write_max_len((phase == 0) ? rxrl_pkg::MAX_LEN_RESET : 7'($urandom_range(0, 127)));
      gaps_on = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 25) begin
        if ($urandom_range(0, 3) != 0) begin
          // Optionally preload the ring while idle, then open a read.
          if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
              send_item(rxrl_pkg::OP_BYTE,
                        ($urandom_range(0, 3) == 0) ? rxrl_pkg::CHAR_NL : 8'($urandom),
                        $urandom);
              sent++;
            end
          end
          send_item(rxrl_pkg::OP_START, 8'($urandom),
                    ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 12)) : 32'($urandom));
          sent++;
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 15);
          for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0) send_item(rxrl_pkg::OP_TICK, 8'($urandom), $urandom);
            else if (r == 1) send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_CR, $urandom);
            else send_item(rxrl_pkg::OP_BYTE, 8'($urandom), $urandom);
            sent++;
          end
          if ($urandom_range(0, 5) != 0) begin
            send_item(rxrl_pkg::OP_BYTE, rxrl_pkg::CHAR_NL, $urandom);
            sent++;
          end
        end else begin
          send_item(rxrl_pkg::op_e'($urandom_range(0, 3)), 8'($urandom), $urandom);
          sent++;
        end
      end
      wait_idle();
    end
  endtask

  // Main sequence.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_line_limits();
    test_ring_backlog();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Receiver stall pattern: runs of no stall, light stall and heavy stall.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run  = $urandom_range(20, 120);
    end
    stall_run--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Result monitor: each accepted beat against the oldest prediction.
  always @(posedge clk_i) begin
    reader_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_beats.size() == 0) begin
        $error("result beat arrived with no prediction waiting");
        fails++;
      end else begin
        want = awaited_beats.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("char_out", 32'(want.ch), 32'(char_out_o));
        check_field("length", 32'(want.len), 32'(length_o));
        check_field("pending", 32'(want.pend), 32'(pending_o));
        check_field("dropped", 32'(want.drop), 32'(dropped_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

endmodule

// ===== rx_ring_line_reader.f =====
sv/rxrl_pkg.sv
sv/rxrl_ram.sv
sv/rx_ring_line_reader.sv
bench/rx_ring_line_reader_test.sv
